@@ rtl/stls_pkg.sv @@
// Package for the sparse triangular level scheduler: widths, request codes,
// status codes, state type. No dependencies.
`default_nettype none
package stls_pkg;
  localparam int unsigned MaxRowsDef = 1024;
  localparam int unsigned LevelW = 10;
  localparam int unsigned RowsW = 11;
  localparam int unsigned FlopsW = 21;
  localparam logic [FlopsW-1:0] FlopsTop = 21'h1FFFFF;
  localparam logic [LevelW-1:0] LevelTop = 10'h3FF;

  typedef enum logic [2:0] {
    REQ_ENTRY  = 3'd0,
    REQ_FINISH = 3'd1,
    REQ_QLEVEL = 3'd2,
    REQ_QROW   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOTFIN = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ENT_RD, S_ENT_WR, S_CLR, S_FIN_CLR, S_FIN_RD, S_FIN_LV,
    S_FIN_WR, S_SUM_RD, S_SUM_ACC, S_Q_RD, S_RESP
  } state_e;

  localparam logic [2:0] CfgRows = 3'd0;
  localparam logic [2:0] CfgThr = 3'd1;

  function automatic logic [FlopsW-1:0] sat_add(input logic [FlopsW-1:0] a,
                                                input logic [FlopsW-1:0] b);
    logic [FlopsW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FlopsW] ? FlopsTop : s[FlopsW-1:0];
  endfunction
endpackage
`default_nettype wire

@@ rtl/stls_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module stls_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/sparse_triangular_level_scheduler_top.sv @@
// Level scheduler: one word per request, one result word per request.
// Entry: column read, row read, write; ignored or diagonal entries: no write.
// Queries: store read, then result; unknown requests: result only. Finish: level
// store sweep, per-row read, lookup, write, then level sum pass; clear: sweep.
// Take a new word when idle; a waiting result stalls the next result and word.
// Reset clears control state and summaries; stores are zero after reset by
// a clear sweep of all MaxRows entries, run before the first word is taken.
// Depends on stls_pkg and stls_ram.
`default_nettype none
module sparse_triangular_level_scheduler_top
  import stls_pkg::*;
#(
  parameter int unsigned MaxRows = MaxRowsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] req_type, [12:3] entry_row, [22:13] entry_col, [32:23] level_sel
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] resp_kind, [4:3] status, [14:5] row_level, [25:15] level_rows,
  // [46:26] level_flops, [47] level_wide, [58:48] num_levels,
  // [79:59] total_flops, [80] any_wide
  output logic [87:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(MaxRows);

  state_e state_q, state_d;
  logic [RowsW-1:0] rows_q;
  logic [9:0] thr_q;
  logic [AW:0] cnt_q, cnt_d;
  logic [2:0] req_q;
  logic [9:0] row_q, col_q, sel_q;
  logic [LevelW-1:0] maxl_q, maxl_d, collvl_q, collvl_d;
  logic [FlopsW-1:0] fsum_q, fsum_d;
  logic wide_q, wide_d, fin_q, fin_d;
  logic [87:0] out_q, out_d;
  logic ovalid_q, ovalid_d;
  logic [LevelW-1:0] flvl_q, flvl_d;
  logic [9:0] fpar_q, fpar_d;

  logic rw_we, lw_we; // row stores, level stores
  logic [AW-1:0] r_wa, r_ra, l_wa, l_ra;
  logic [LevelW-1:0] rl_wd, rl_rd;
  logic [9:0] rp_wd, rp_rd;
  logic rl_we, rp_we;
  logic [RowsW-1:0] lc_wd, lc_rd;
  logic [FlopsW-1:0] lf_wd, lf_rd;
  logic lwd_wd, lwd_rd;

  stls_ram #(.Width(LevelW), .Depth(MaxRows)) u_rlvl (
    .clk_i, .we_i(rl_we), .waddr_i(r_wa), .wdata_i(rl_wd), .raddr_i(r_ra), .rdata_o(rl_rd));
  stls_ram #(.Width(10), .Depth(MaxRows)) u_rpar (
    .clk_i, .we_i(rp_we), .waddr_i(r_wa), .wdata_i(rp_wd), .raddr_i(r_ra), .rdata_o(rp_rd));
  stls_ram #(.Width(RowsW), .Depth(MaxRows)) u_lcnt (
    .clk_i, .we_i(lw_we), .waddr_i(l_wa), .wdata_i(lc_wd), .raddr_i(l_ra), .rdata_o(lc_rd));
  stls_ram #(.Width(FlopsW), .Depth(MaxRows)) u_lflp (
    .clk_i, .we_i(lw_we), .waddr_i(l_wa), .wdata_i(lf_wd), .raddr_i(l_ra), .rdata_o(lf_rd));
  stls_ram #(.Width(1), .Depth(MaxRows)) u_lwid (
    .clk_i, .we_i(lw_we), .waddr_i(l_wa), .wdata_i(lwd_wd), .raddr_i(l_ra), .rdata_o(lwd_rd));

  logic [AW:0] nrows;
  always_comb begin
    nrows = (rows_q == '0) ? (AW+1)'(1) :
            ({21'd0, rows_q} > 32'(MaxRows)) ? (AW+1)'(MaxRows) : (AW+1)'(rows_q);
  end

  logic acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = out_q;

  logic [LevelW:0] lvl_inc;
  logic [RowsW:0] cnt_inc;
  logic [FlopsW-1:0] add_f;
  logic [87:0] resp;
  status_e st;
  logic [9:0] rlev;
  logic [RowsW-1:0] lrows;
  logic [FlopsW-1:0] lfl;
  logic lwv;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; maxl_d = maxl_q; collvl_d = collvl_q;
    fsum_d = fsum_q; wide_d = wide_q; fin_d = fin_q; out_d = out_q;
    ovalid_d = ovalid_q && !m_axis_tready; flvl_d = flvl_q; fpar_d = fpar_q;
    rl_we = 1'b0; rp_we = 1'b0; lw_we = 1'b0;
    r_wa = cnt_q[AW-1:0]; r_ra = cnt_q[AW-1:0]; l_wa = cnt_q[AW-1:0];
    l_ra = cnt_q[AW-1:0];
    rl_wd = '0; rp_wd = '0; lc_wd = '0; lf_wd = '0; lwd_wd = 1'b0;
    lvl_inc = {1'b0, collvl_q} + 1'b1;
    cnt_inc = {1'b0, lc_rd} + 1'b1;
    add_f = {10'd0, fpar_q, 1'b1};
    st = ST_OK; rlev = '0; lrows = '0; lfl = '0; lwv = 1'b0;
    resp = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          cnt_d = '0;
          unique case (s_axis_tdata[2:0])
            REQ_ENTRY: begin
              r_ra = AW'(s_axis_tdata[22:13]);
              state_d = S_ENT_RD;
            end
            REQ_FINISH: state_d = S_FIN_CLR;
            REQ_QLEVEL: begin
              l_ra = AW'(s_axis_tdata[32:23]);
              state_d = S_Q_RD;
            end
            REQ_QROW: begin
              r_ra = AW'(s_axis_tdata[12:3]);
              state_d = S_Q_RD;
            end
            REQ_CLEAR: state_d = S_CLR;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_ENT_RD: begin
        collvl_d = rl_rd;
        r_ra = AW'(row_q);
        state_d = S_ENT_WR;
        if ({1'b0, row_q} >= nrows || {1'b0, col_q} >= nrows || row_q <= col_q)
          state_d = S_RESP;
      end
      S_ENT_WR: begin
        r_wa = AW'(row_q);
        if (lvl_inc[LevelW]) lvl_inc = {1'b0, LevelTop};
        rl_wd = (lvl_inc[LevelW-1:0] > rl_rd) ? lvl_inc[LevelW-1:0] : rl_rd;
        rp_wd = (rp_rd < 10'h3FF) ? rp_rd + 1'b1 : rp_rd;
        rl_we = 1'b1; rp_we = 1'b1;
        fin_d = 1'b0;
        state_d = S_RESP;
      end
      S_CLR: begin
        rl_we = 1'b1; rp_we = 1'b1; lw_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(MaxRows - 1)) begin
          maxl_d = '0; fsum_d = '0; wide_d = 1'b0; fin_d = 1'b0;
          state_d = ovalid_q && !m_axis_tready ? S_CLR : S_RESP;
          cnt_d = cnt_q;
          if (req_q != REQ_CLEAR) state_d = S_IDLE;
        end
      end
      S_FIN_CLR: begin
        lw_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(MaxRows - 1)) begin
          maxl_d = '0; fsum_d = '0; wide_d = 1'b0; cnt_d = '0;
          state_d = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        state_d = S_FIN_LV;
      end
      S_FIN_LV: begin
        flvl_d = rl_rd; fpar_d = rp_rd;
        l_ra = AW'(rl_rd);
        state_d = S_FIN_WR;
      end
      S_FIN_WR: begin
        l_wa = AW'(flvl_q);
        lw_we = 1'b1;
        lc_wd = cnt_inc[RowsW-1:0];
        lf_wd = sat_add(lf_rd, add_f);
        lwd_wd = lwd_rd || (fpar_q > thr_q);
        if (fpar_q > thr_q) wide_d = 1'b1;
        if (flvl_q > maxl_q) maxl_d = flvl_q;
        cnt_d = cnt_q + 1'b1;
        r_ra = AW'(cnt_q + 1'b1);
        state_d = S_FIN_RD;
        if (cnt_q + 1'b1 == nrows) begin
          cnt_d = '0; state_d = S_SUM_RD;
        end
      end
      S_SUM_RD: begin
        l_ra = cnt_q[AW-1:0];
        state_d = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        fsum_d = sat_add(fsum_q, lf_rd);
        cnt_d = cnt_q + 1'b1;
        state_d = S_SUM_RD;
        if (cnt_q[AW-1:0] == AW'(maxl_q) || cnt_q == (AW+1)'(MaxRows - 1)) begin
          fin_d = 1'b1; state_d = S_RESP;
        end
      end
      S_Q_RD: begin
        r_ra = AW'(row_q);
        l_ra = AW'(sel_q);
        state_d = S_RESP;
      end
      S_RESP: begin
        r_ra = AW'(row_q);
        l_ra = AW'(sel_q);
        unique case (req_q) inside
          REQ_ENTRY: st = ({1'b0, row_q} >= nrows || {1'b0, col_q} >= nrows ||
                          row_q < col_q) ? ST_RANGE : ST_OK;
          REQ_FINISH, REQ_CLEAR: st = ST_OK;
          REQ_QLEVEL: begin
            if (!fin_q) st = ST_NOTFIN;
            else if (sel_q > maxl_q || {22'd0, sel_q} >= MaxRows) st = ST_RANGE;
            else begin
              lrows = lc_rd; lfl = lf_rd; lwv = lwd_rd;
            end
          end
          REQ_QROW: begin
            if (!fin_q) st = ST_NOTFIN;
            else if ({1'b0, row_q} >= nrows) st = ST_RANGE;
            else rlev = rl_rd;
          end
          default: st = ST_RANGE;
        endcase
        resp = {7'd0, fin_q & wide_q, fin_q ? fsum_q : '0,
                fin_q ? ({1'b0, maxl_q} + 11'd1) : 11'd0,
                lwv, lfl, lrows, rlev, st, req_q};
        if (!ovalid_q || m_axis_tready) begin
          out_d = resp; ovalid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; cnt_q <= '0; rows_q <= 11'd1024; thr_q <= 10'd4;
      maxl_q <= '0; fsum_q <= '0; wide_q <= 1'b0; fin_q <= 1'b0;
      ovalid_q <= 1'b0; req_q <= REQ_FINISH;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; maxl_q <= maxl_d; fsum_q <= fsum_d;
      wide_q <= wide_d; fin_q <= fin_d; ovalid_q <= ovalid_d;
      if (acc) req_q <= s_axis_tdata[2:0];
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgRows[0:0]) rows_q <= cfg_data_i;
        else thr_q <= cfg_data_i[9:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d; collvl_q <= collvl_d; flvl_q <= flvl_d; fpar_q <= fpar_d;
    if (acc) begin
      row_q <= s_axis_tdata[12:3]; col_q <= s_axis_tdata[22:13];
      sel_q <= s_axis_tdata[32:23];
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE)
    else $error("accept while busy");
  a_fin_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fin_q) |-> $past(state_q) == S_SUM_ACC)
    else $error("finished set outside sum pass");
endmodule
`default_nettype wire

@@ tb/sparse_triangular_level_scheduler_top_tb.sv @@
// Testbench for the sparse triangular level scheduler: drives request words,
// predicts every result word and compares them in a scoreboard class.
// Depends on stls_pkg and sparse_triangular_level_scheduler_top.
`default_nettype none
module sparse_triangular_level_scheduler_top_tb
  import stls_pkg::*;
();

  localparam int NRows = 1024;

  class level_scoreboard;
    int unsigned rows_cfg = 1024;
    int unsigned thr_cfg = 4;
    int unsigned row_lvl[NRows];
    int unsigned row_par[NRows];
    int unsigned lv_cnt[NRows];
    int unsigned lv_flops[NRows];
    bit lv_wide[NRows];
    int unsigned max_lvl, flops_tot;
    bit wide_any, done;
    logic [80:0] pending[$];
    int errors;

    function void wipe_stats();
      foreach (lv_cnt[i]) begin
        lv_cnt[i] = 0; lv_flops[i] = 0; lv_wide[i] = 0;
      end
      max_lvl = 0; flops_tot = 0; wide_any = 0;
    endfunction

    function void wipe_all();
      foreach (row_lvl[i]) begin
        row_lvl[i] = 0; row_par[i] = 0;
      end
      wipe_stats();
      done = 0;
    endfunction

    function int unsigned rows_used();
      if (rows_cfg < 1) return 1;
      if (rows_cfg > NRows) return NRows;
      return rows_cfg;
    endfunction

    function int unsigned sat(int unsigned a, int unsigned b);
      return (a + b > 2097151) ? 2097151 : a + b;
    endfunction

    function void note_request(logic [39:0] w);
      logic [2:0] req;
      int unsigned row, col, sel, n, st, rl, lr, lf, lw, lvl;
      logic [80:0] exp_w;
      req = w[2:0]; row = w[12:3]; col = w[22:13]; sel = w[32:23];
      st = ST_OK; rl = 0; lr = 0; lf = 0; lw = 0; n = rows_used();
      case (req)
        REQ_ENTRY: begin
          if (row >= n || col >= n || row < col) st = ST_RANGE;
          else if (row != col) begin
            lvl = row_lvl[col] + 1;
            if (lvl > 1023) lvl = 1023;
            if (lvl > row_lvl[row]) row_lvl[row] = lvl;
            if (row_par[row] < 1023) row_par[row]++;
            done = 0;
          end
        end
        REQ_FINISH: begin
          wipe_stats();
          for (int r = 0; r < n; r++) begin
            lvl = row_lvl[r];
            if (lvl > max_lvl) max_lvl = lvl;
            lv_cnt[lvl]++;
            lv_flops[lvl] = sat(lv_flops[lvl], 2 * row_par[r] + 1);
            if (row_par[r] > thr_cfg) begin
              lv_wide[lvl] = 1; wide_any = 1;
            end
          end
          for (int l = 0; l <= max_lvl; l++) flops_tot = sat(flops_tot, lv_flops[l]);
          done = 1;
        end
        REQ_QLEVEL: begin
          if (!done) st = ST_NOTFIN;
          else if (sel > max_lvl) st = ST_RANGE;
          else begin
            lr = lv_cnt[sel]; lf = lv_flops[sel]; lw = lv_wide[sel];
          end
        end
        REQ_QROW: begin
          if (!done) st = ST_NOTFIN;
          else if (row >= n) st = ST_RANGE;
          else rl = row_lvl[row];
        end
        REQ_CLEAR: wipe_all();
        default: st = ST_RANGE;
      endcase
      exp_w = {done ? 1'(wide_any) : 1'b0,
               done ? 21'(flops_tot) : 21'd0,
               done ? 11'(max_lvl + 1) : 11'd0,
               1'(lw), 21'(lf), 11'(lr), 10'(rl), 2'(st), req};
      pending.insert(pending.size(), exp_w);
    endfunction

    function void check_result(logic [87:0] got);
      logic [80:0] exp_w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got[80:0] !== exp_w || got[87:81] !== 7'd0) begin
        errors++;
        if (errors <= 10) $display("result: expected %h actual %h", exp_w, got[80:0]);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, m_axis_tready = 0, cfg_we_i = 0;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0] cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic s_axis_tready, m_axis_tvalid;
  logic [87:0] m_axis_tdata;
  level_scoreboard sb;
  int idle_cnt;
  bit hold_sink;

  sparse_triangular_level_scheduler_top u_dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  task automatic send_request(logic [2:0] req, int row, int col, int sel);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'd0, 10'(sel), 10'(col), 10'(row), req};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(s_axis_tdata);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3100) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [0:0] idx, int val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= 11'(val);
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CfgRows[0]) sb.rows_cfg = val; else sb.thr_cfg = val;
    @(posedge clk_i);
  endtask

  task automatic random_matrix(int n, int entries);
    int col, row;
    col = 0;
    for (int k = 0; k < entries; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
      end else begin
        if ($urandom_range(0, 3) == 0 && col < n - 1) col++;
        row = (col < n - 1) ? $urandom_range(col, n - 1) : col;
        if ($urandom_range(0, 19) == 0) row = $urandom_range(0, 1023);
        send_request(REQ_ENTRY, row, col, $urandom);
      end
    end
    send_request(REQ_FINISH, $urandom, $urandom, $urandom);
    for (int k = 0; k < 12; k++) begin
      send_request(REQ_QROW, $urandom_range(0, n + 2), 0, $urandom);
      send_request(REQ_QLEVEL, $urandom, 0, $urandom_range(0, 12));
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin : sink
    int w;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 0;
        repeat (200) @(posedge clk_i);
        hold_sink = 0;
        m_axis_tready <= 1;
      end else begin
        w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
        if (w == 0) m_axis_tready <= 1;
        else begin
          m_axis_tready <= 0;
          repeat (w) @(posedge clk_i);
          m_axis_tready <= 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000) begin
      $display("sparse_triangular_level_scheduler_top: mismatch");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.wipe_all();
    idle_cnt = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    send_request(REQ_QROW, 0, 0, 0);
    send_request(REQ_ENTRY, 1023, 0, 0);
    send_request(REQ_ENTRY, 0, 1023, 0);
    send_request(REQ_ENTRY, 5, 5, 0);
    send_request(REQ_ENTRY, 3, 1, 0);
    send_request(REQ_ENTRY, 7, 3, 0);
    for (int k = 0; k < 6; k++) send_request(REQ_ENTRY, 9, k, 0);
    send_request(REQ_FINISH, 0, 0, 0);
    send_request(REQ_QLEVEL, 0, 0, 0);
    send_request(REQ_QLEVEL, 0, 0, 2);
    send_request(REQ_QLEVEL, 0, 0, 1023);
    send_request(REQ_QROW, 7, 0, 0);
    send_request(REQ_QROW, 1023, 0, 0);
    send_request(3'd5, 1, 1, 1);
    send_request(3'd7, 1023, 1023, 1023);
    send_request(REQ_CLEAR, 0, 0, 0);
    send_request(REQ_FINISH, 0, 0, 0);
    send_request(REQ_QLEVEL, 0, 0, 0);
    drain();
    write_cfg(CfgRows[0], 4);
    write_cfg(CfgThr[0], 0);
    send_request(REQ_ENTRY, 3, 0, 0);
    send_request(REQ_ENTRY, 3, 2, 0);
    send_request(REQ_ENTRY, 4, 0, 0);
    send_request(REQ_FINISH, 0, 0, 0);
    send_request(REQ_QROW, 3, 0, 0);
    send_request(REQ_QROW, 4, 0, 0);
    hold_sink = 1;
    for (int k = 0; k < 30; k++) send_request(REQ_QLEVEL, 0, 0, $urandom_range(0, 2));
    drain();
    for (int ph = 0; ph < 24; ph++) begin
      send_request(REQ_CLEAR, 0, 0, 0);
      drain();
      case (ph % 6)
        0: write_cfg(CfgRows[0], 1);
        1: write_cfg(CfgRows[0], 0);
        2: write_cfg(CfgRows[0], 2047);
        default: write_cfg(CfgRows[0], $urandom_range(2, 40));
      endcase
      write_cfg(CfgThr[0], (ph % 5 == 0) ? 1023 : $urandom_range(0, 6));
      random_matrix(sb.rows_used() > 64 ? 64 : sb.rows_used(), 50);
      if (ph == 10) hold_sink = 1;
    end
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("sparse_triangular_level_scheduler_top: match");
    else
      $display("sparse_triangular_level_scheduler_top: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
